[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, quiet during reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on i_clk, quiet during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/kerh_pkg.sv]
// ----------------------------------------------------------------------------
// kerh_pkg
// Types, frame tables and codes of the key event reporter.
// ----------------------------------------------------------------------------
package kerh_pkg;

    localparam int KEY_COUNT  = 7;
    localparam int HB_LEN     = 5;
    localparam int EV_MAX_LEN = 7;
    localparam int QDEPTH     = 2;

    localparam logic [19:0] CNT_MAX         = 20'hFFFFF;
    localparam logic [19:0] TIMEOUT_RESET   = 20'd10000;
    localparam logic [9:0]  SCAN_RESET      = 10'd100;

    localparam logic [7:0] RX_START = 8'hCA;
    localparam logic [7:0] RX_END   = 8'hAC;
    localparam logic [7:0] EV_START = 8'hBA;
    localparam logic [7:0] EV_END   = 8'hAB;

    // door1 and door2 read active low
    localparam logic [KEY_COUNT-1:0] INV_MASK = 7'b0011000;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_SCAN    = 2'd1;

    localparam logic [7:0] HB_FRAME [HB_LEN] = '{8'hCA, 8'h10, 8'h00, 8'h10, 8'hAC};

    localparam logic [2:0] EV_LEN [KEY_COUNT] =
        '{3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd6, 3'd6};

    // [key][release][byte]
    localparam logic [7:0] EV_FRAME [KEY_COUNT][2][EV_MAX_LEN] = '{
        '{'{8'hBA, 8'h11, 8'h01, 8'h01, 8'h13, 8'hAB, 8'h00},
          '{8'hBA, 8'h11, 8'h01, 8'h02, 8'h14, 8'hAB, 8'h00}},
        '{'{8'hBA, 8'h12, 8'h01, 8'h01, 8'h14, 8'hAB, 8'h00},
          '{8'hBA, 8'h12, 8'h01, 8'h02, 8'h15, 8'hAB, 8'h00}},
        '{'{8'hBA, 8'h17, 8'h01, 8'h01, 8'h19, 8'hAB, 8'h00},
          '{8'hBA, 8'h17, 8'h01, 8'h02, 8'h20, 8'hAB, 8'h00}},
        '{'{8'hBA, 8'h13, 8'h02, 8'h01, 8'h01, 8'h17, 8'hAB},
          '{8'hBA, 8'h13, 8'h02, 8'h01, 8'h02, 8'h18, 8'hAB}},
        '{'{8'hBA, 8'h13, 8'h02, 8'h02, 8'h01, 8'h18, 8'hAB},
          '{8'hBA, 8'h13, 8'h02, 8'h02, 8'h02, 8'h19, 8'hAB}},
        '{'{8'hBA, 8'h14, 8'h01, 8'h01, 8'h16, 8'hAB, 8'h00},
          '{8'hBA, 8'h14, 8'h01, 8'h02, 8'h17, 8'hAB, 8'h00}},
        '{'{8'hBA, 8'h15, 8'h01, 8'h01, 8'h17, 8'hAB, 8'h00},
          '{8'hBA, 8'h15, 8'h01, 8'h02, 8'h18, 8'hAB, 8'h00}}
    };

    // work handed from the front to the back for one tick
    typedef struct packed {
        logic                 hb;
        logic [KEY_COUNT-1:0] press;
        logic [KEY_COUNT-1:0] release_k;
    } t_job;

endpackage

[sv/kerh_queue.sv]
// ----------------------------------------------------------------------------
// kerh_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module kerh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kerh_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output kerh_pkg::t_job o_job
);
    import kerh_pkg::*;

    t_job       r_mem [QDEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(QDEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[sv/kerh_front.sv]
// ----------------------------------------------------------------------------
// kerh_front
// Accepts ticks and link bytes, runs the heartbeat receiver, the watchdog and
// the key scan, and issues one job per tick that has frames to send.
// ----------------------------------------------------------------------------
module kerh_front #(
    parameter int NUM_KEYS     = 7,
    parameter int MAX_RX_FRAME = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [19:0]                     i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_opcode,
    input  logic [kerh_pkg::KEY_COUNT-1:0]  i_key_down,
    input  logic [7:0]                      i_rx_byte,
    input  logic                            i_full,
    output logic                            o_push,
    output kerh_pkg::t_job                  o_job
);
    import kerh_pkg::*;

    localparam int SCAN_KEYS = (NUM_KEYS < KEY_COUNT) ? NUM_KEYS : KEY_COUNT;
    localparam logic [KEY_COUNT-1:0] KEY_MASK = KEY_COUNT'((1 << SCAN_KEYS) - 1);
    localparam logic [5:0] RX_LIMIT = 6'(MAX_RX_FRAME);

    logic [19:0]          r_timeout;
    logic [9:0]           r_period;
    logic [19:0]          r_silence;
    logic [9:0]           r_phase;
    logic                 r_armed;
    logic [KEY_COUNT-1:0] r_held;
    logic                 r_in_frame;
    logic [5:0]           r_pos;
    logic                 r_matching;

    logic                 accept;
    logic                 is_tick;
    logic [19:0]          sil_inc;
    logic                 fire;
    logic [9:0]           phase_inc;
    logic                 scan;
    logic [KEY_COUNT-1:0] active;
    logic [5:0]           pos_inc;
    logic                 byte_ok;
    logic                 match_next;
    logic                 hb_ok;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign is_tick = !i_opcode;

    assign sil_inc   = (r_silence != CNT_MAX) ? r_silence + 20'd1 : r_silence;
    assign fire      = r_armed && (sil_inc > r_timeout);
    assign phase_inc = r_phase + 10'd1;
    assign scan      = (phase_inc >= r_period);
    assign active    = (i_key_down ^ INV_MASK) & KEY_MASK;

    assign o_job.hb        = fire;
    assign o_job.press     = scan ? (active & ~r_held) : '0;
    assign o_job.release_k = scan ? (~active & r_held) : '0;
    assign o_push = accept && is_tick &&
                    (o_job.hb || (o_job.press != '0) || (o_job.release_k != '0));

    assign pos_inc    = r_pos + 6'd1;
    assign byte_ok    = (r_pos < 6'(HB_LEN)) && (i_rx_byte == HB_FRAME[r_pos[2:0]]);
    assign match_next = r_matching && byte_ok;
    assign hb_ok      = match_next && (pos_inc == 6'(HB_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_period   <= SCAN_RESET;
            r_silence  <= '0;
            r_phase    <= 10'd1;
            r_armed    <= 1'b0;
            r_held     <= '0;
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_matching <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_SCAN:    r_period  <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (accept && is_tick) begin
                r_silence <= fire ? '0 : sil_inc;
                if (fire) begin
                    r_armed <= 1'b0;
                end
                r_phase <= scan ? '0 : phase_inc;
                if (scan) begin
                    r_held <= active;
                end
            end else if (accept) begin
                if (!r_in_frame) begin
                    if (i_rx_byte == RX_START) begin
                        r_in_frame <= 1'b1;
                        r_pos      <= 6'd1;
                        r_matching <= 1'b1;
                    end
                end else if (i_rx_byte == RX_END) begin
                    if (hb_ok) begin
                        r_silence <= '0;
                        r_armed   <= 1'b1;
                    end
                    r_in_frame <= 1'b0;
                    r_pos      <= '0;
                    r_matching <= 1'b0;
                end else if (pos_inc >= RX_LIMIT) begin
                    r_in_frame <= 1'b0;
                    r_pos      <= '0;
                    r_matching <= 1'b0;
                end else begin
                    r_pos      <= pos_inc;
                    r_matching <= match_next;
                end
            end
        end
    end

endmodule

[sv/kerh_back.sv]
// ----------------------------------------------------------------------------
// kerh_back
// Expands one job into heartbeat and key event frame bytes, one byte per
// cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module kerh_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  kerh_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_tx_byte,
    output logic           o_frame_end,
    output logic           o_run_last,
    output logic           o_reboot_pulse
);
    import kerh_pkg::*;

    logic                 r_hb;
    logic [KEY_COUNT-1:0] r_keys;
    logic [KEY_COUNT-1:0] r_rel;
    logic [2:0]           r_bi;
    logic                 r_o_valid;
    logic [7:0]           r_o_byte;
    logic                 r_o_end;
    logic                 r_o_last;
    logic                 r_o_pulse;

    logic                 idle;
    logic                 advance;
    logic [2:0]           cur_k;
    logic [KEY_COUNT-1:0] keys_left;
    logic [7:0]           n_byte;
    logic                 n_end;
    logic                 n_last;
    logic                 n_pulse;

    function automatic logic [2:0] lowest_key(input logic [KEY_COUNT-1:0] m);
        logic [2:0] k;
        k = '0;
        for (int i = KEY_COUNT - 1; i >= 0; i--) begin
            if (m[i]) begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

    assign idle    = !r_hb && (r_keys == '0);
    assign advance = !r_o_valid || !i_stall;
    assign o_pop   = idle && !i_empty;
    assign cur_k   = lowest_key(r_keys);

    always_comb begin
        keys_left        = r_keys;
        keys_left[cur_k] = 1'b0;
        if (r_hb) begin
            n_byte  = HB_FRAME[r_bi];
            n_end   = (r_bi == 3'(HB_LEN - 1));
            n_pulse = (r_bi == 3'd0);
            n_last  = n_end && (r_keys == '0);
        end else begin
            n_byte  = EV_FRAME[cur_k][r_rel[cur_k]][r_bi];
            n_end   = (r_bi == EV_LEN[cur_k] - 3'd1);
            n_pulse = 1'b0;
            n_last  = n_end && (keys_left == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hb      <= 1'b0;
            r_keys    <= '0;
            r_rel     <= '0;
            r_bi      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_hb   <= i_job.hb;
                r_keys <= i_job.press | i_job.release_k;
                r_rel  <= i_job.release_k;
                r_bi   <= '0;
            end else if (!idle && advance) begin
                if (n_end) begin
                    r_bi <= '0;
                    if (r_hb) begin
                        r_hb <= 1'b0;
                    end else begin
                        r_keys <= keys_left;
                    end
                end else begin
                    r_bi <= r_bi + 3'd1;
                end
            end
            if (advance) begin
                r_o_valid <= !idle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_byte  <= n_byte;
            r_o_end   <= n_end;
            r_o_last  <= n_last;
            r_o_pulse <= n_pulse;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_tx_byte      = r_o_byte;
    assign o_frame_end    = r_o_end;
    assign o_run_last     = r_o_last;
    assign o_reboot_pulse = r_o_pulse;

endmodule

[sv/key_event_reporter_with_heartbeat.sv]
// ----------------------------------------------------------------------------
// key_event_reporter_with_heartbeat
// Key event reporter with heartbeat watchdog: top level.
// ----------------------------------------------------------------------------
// Ticks and link bytes are accepted back to back while the two-entry job
// queue has room, and a link byte or a quiet tick leaves nothing behind. A
// tick that has frames to send queues one job; the back end then emits its
// bytes at one byte per cycle while the output is not stalled (5 for a
// watchdog heartbeat, 6 or 7 per key event, at most 49), and it loads the
// next job from the queue only once it is idle. The output register sets
// the rate, and the input stalls only when two jobs are already waiting.
module key_event_reporter_with_heartbeat #(
    parameter int NUM_KEYS     = 7,
    parameter int MAX_RX_FRAME = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [19:0]                    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_opcode,
    input  logic [kerh_pkg::KEY_COUNT-1:0] i_key_down,
    input  logic [7:0]                     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_tx_byte,
    output logic                           o_frame_end,
    output logic                           o_run_last,
    output logic                           o_reboot_pulse
);
    import kerh_pkg::*;

    t_job push_job;
    t_job pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    kerh_front #(
        .NUM_KEYS     (NUM_KEYS),
        .MAX_RX_FRAME (MAX_RX_FRAME)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_opcode   (i_opcode),
        .i_key_down (i_key_down),
        .i_rx_byte  (i_rx_byte),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job)
    );

    kerh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (pop_job)
    );

    kerh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_job          (pop_job),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tx_byte      (o_tx_byte),
        .o_frame_end    (o_frame_end),
        .o_run_last     (o_run_last),
        .o_reboot_pulse (o_reboot_pulse)
    );

endmodule

[sv/kerh_checker.sv]
// ----------------------------------------------------------------------------
// kerh_checker
// Port-level checks on the output frames of the key event reporter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kerh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_tx_byte,
    input logic       o_frame_end,
    input logic       o_run_last,
    input logic       o_reboot_pulse
);
    import kerh_pkg::*;

    `ASSERT_NEXT(a_hold_valid, o_valid && i_stall, o_valid)
    `ASSERT_SAME(a_pulse_on_start, o_valid && o_reboot_pulse, (o_tx_byte == RX_START) && !o_frame_end)
    `ASSERT_SAME(a_last_ends_frame, o_valid && o_run_last, o_frame_end)
    `ASSERT_SAME(a_end_byte, o_valid && o_frame_end, (o_tx_byte == RX_END) || (o_tx_byte == EV_END))

endmodule

bind key_event_reporter_with_heartbeat kerh_checker u_kerh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_tx_byte      (o_tx_byte),
    .o_frame_end    (o_frame_end),
    .o_run_last     (o_run_last),
    .o_reboot_pulse (o_reboot_pulse)
);

[verif/key_event_reporter_with_heartbeat_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_reporter_with_heartbeat_test
// Self-checking bench for the key event reporter with heartbeat watchdog.
// ----------------------------------------------------------------------------
// A directed table walks the key edges, the watchdog reboot and the link
// frame corner cases, then randomized phases mix well-formed heartbeat
// frames, broken frames and ticks with toggling keys under several register
// settings and idle/stall patterns. Every transmitted byte is compared with a
// cycle-free predictor of the block kept in this file.
// ----------------------------------------------------------------------------
module key_event_reporter_with_heartbeat_test;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LINK = 1'b1;

    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam int          MAX_FRAME   = 32;
    localparam logic [7:0]  FRAME_OPEN  = 8'hCA;
    localparam logic [7:0]  FRAME_CLOSE = 8'hAC;
    localparam logic [19:0] SILENCE_MAX = 20'hFFFFF;
    localparam int unsigned CYCLE_LIMIT = 1000000;

    localparam logic [7:0] HB_BYTES [5] = '{8'hCA, 8'h10, 8'h00, 8'h10, 8'hAC};
    localparam logic [6:0] DOOR_KEYS = 7'b0011000;
    localparam int KEY_FRAME_LEN [7] = '{6, 6, 6, 7, 7, 6, 6};
    // [key][0 press, 1 release][byte]
    localparam logic [7:0] KEY_FRAMES [7][2][7] = '{
        '{'{8'hBA, 8'h11, 8'h01, 8'h01, 8'h13, 8'hAB, 8'h00},
          '{8'hBA, 8'h11, 8'h01, 8'h02, 8'h14, 8'hAB, 8'h00}},
        '{'{8'hBA, 8'h12, 8'h01, 8'h01, 8'h14, 8'hAB, 8'h00},
          '{8'hBA, 8'h12, 8'h01, 8'h02, 8'h15, 8'hAB, 8'h00}},
        '{'{8'hBA, 8'h17, 8'h01, 8'h01, 8'h19, 8'hAB, 8'h00},
          '{8'hBA, 8'h17, 8'h01, 8'h02, 8'h20, 8'hAB, 8'h00}},
        '{'{8'hBA, 8'h13, 8'h02, 8'h01, 8'h01, 8'h17, 8'hAB},
          '{8'hBA, 8'h13, 8'h02, 8'h01, 8'h02, 8'h18, 8'hAB}},
        '{'{8'hBA, 8'h13, 8'h02, 8'h02, 8'h01, 8'h18, 8'hAB},
          '{8'hBA, 8'h13, 8'h02, 8'h02, 8'h02, 8'h19, 8'hAB}},
        '{'{8'hBA, 8'h14, 8'h01, 8'h01, 8'h16, 8'hAB, 8'h00},
          '{8'hBA, 8'h14, 8'h01, 8'h02, 8'h17, 8'hAB, 8'h00}},
        '{'{8'hBA, 8'h15, 8'h01, 8'h01, 8'h17, 8'hAB, 8'h00},
          '{8'hBA, 8'h15, 8'h01, 8'h02, 8'h18, 8'hAB, 8'h00}}
    };

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
        logic       run_last;
        logic       reboot;
    } t_tx_beat;

    typedef struct packed {
        logic       op;
        logic [6:0] keys;
        logic [7:0] rx;
        int         n_bytes;
    } t_stim_row;

    // timeout 0, scan every tick
    localparam t_stim_row DIRECTED [25] = '{
        '{OP_TICK, 7'h18, 8'hFF, 0},
        '{OP_TICK, 7'h00, 8'h00, 14},
        '{OP_TICK, 7'h7F, 8'hFF, 44},
        '{OP_TICK, 7'h7F, 8'h00, 0},
        '{OP_TICK, 7'h18, 8'hFF, 30},
        '{OP_LINK, 7'h7F, 8'hCA, 0},
        '{OP_LINK, 7'h00, 8'h10, 0},
        '{OP_LINK, 7'h7F, 8'h00, 0},
        '{OP_LINK, 7'h00, 8'h10, 0},
        '{OP_LINK, 7'h7F, 8'hAC, 0},
        '{OP_TICK, 7'h67, 8'hFF, 49},
        '{OP_LINK, 7'h00, 8'h55, 0},
        '{OP_LINK, 7'h7F, 8'hCA, 0},
        '{OP_LINK, 7'h00, 8'hCA, 0},
        '{OP_LINK, 7'h7F, 8'h10, 0},
        '{OP_LINK, 7'h00, 8'h00, 0},
        '{OP_LINK, 7'h7F, 8'h10, 0},
        '{OP_LINK, 7'h00, 8'hAC, 0},
        '{OP_TICK, 7'h67, 8'h00, 0},
        '{OP_LINK, 7'h7F, 8'hCA, 0},
        '{OP_LINK, 7'h00, 8'h10, 0},
        '{OP_LINK, 7'h7F, 8'h00, 0},
        '{OP_LINK, 7'h00, 8'h11, 0},
        '{OP_LINK, 7'h7F, 8'hAC, 0},
        '{OP_TICK, 7'h18, 8'hFF, 44}
    };

    logic                           i_clk;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [1:0]                     i_cfg_idx  = '0;
    logic [19:0]                    i_cfg_data = '0;
    logic                           i_valid    = 1'b0;
    logic                           o_stall;
    logic                           i_opcode   = 1'b0;
    logic [kerh_pkg::KEY_COUNT-1:0] i_key_down = '0;
    logic [7:0]                     i_rx_byte  = '0;
    logic                           o_valid;
    logic                           i_stall    = 1'b0;
    logic [7:0]                     o_tx_byte;
    logic                           o_frame_end;
    logic                           o_run_last;
    logic                           o_reboot_pulse;

    key_event_reporter_with_heartbeat i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_key_down     (i_key_down),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tx_byte      (o_tx_byte),
        .o_frame_end    (o_frame_end),
        .o_run_last     (o_run_last),
        .o_reboot_pulse (o_reboot_pulse)
    );

    // predictor state
    logic [19:0] timeout_reg;
    logic [9:0]  scan_period_reg;
    logic [19:0] silence_ms;
    logic [9:0]  scan_tick;
    logic        wd_armed;
    logic [6:0]  keys_held;
    logic        in_frame;
    logic [5:0]  frame_pos;
    logic        frame_ok;

    t_tx_beat    tx_expected [$];
    t_tx_beat    rx_want;
    int          last_burst;
    int          mismatches;
    int          items_sent;
    int          bytes_checked;
    int          reboots_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned cycles = 0;
    logic [6:0]  cur_keys;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** key_event_reporter_with_heartbeat: FAILED **");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic int predict_tx(input logic op, input logic [6:0] keys,
                                      input logic [7:0] rx);
        t_tx_beat burst [$];
        t_tx_beat beat;
        logic     dn;
        logic     act;
        int       which;
        if (op == OP_LINK) begin
            if (!in_frame) begin
                if (rx == FRAME_OPEN) begin
                    in_frame  = 1'b1;
                    frame_pos = 6'd1;
                    frame_ok  = 1'b1;
                end
            end else begin
                if (!(frame_pos < 5 && rx == HB_BYTES[frame_pos])) frame_ok = 1'b0;
                frame_pos = frame_pos + 6'd1;
                if (rx == FRAME_CLOSE) begin
                    if (frame_ok && frame_pos == 6'd5) begin
                        silence_ms = '0;
                        wd_armed   = 1'b1;
                    end
                    in_frame  = 1'b0;
                    frame_pos = '0;
                    frame_ok  = 1'b0;
                end else if (frame_pos >= MAX_FRAME) begin
                    in_frame  = 1'b0;
                    frame_pos = '0;
                    frame_ok  = 1'b0;
                end
            end
            return 0;
        end
        if (silence_ms != SILENCE_MAX) silence_ms = silence_ms + 20'd1;
        if (wd_armed && silence_ms > timeout_reg) begin
            for (int i = 0; i < 5; i++) begin
                beat = '{HB_BYTES[i], i == 4, 1'b0, i == 0};
                burst.push_back(beat);
            end
            silence_ms = '0;
            wd_armed   = 1'b0;
            reboots_seen++;
        end
        scan_tick = scan_tick + 10'd1;
        if (scan_tick >= scan_period_reg) begin
            scan_tick = '0;
            for (int k = 0; k < 7; k++) begin
                dn    = keys[k];
                act   = DOOR_KEYS[k] ? !dn : dn;
                which = -1;
                if (act) begin
                    if (!keys_held[k]) which = 0;
                    keys_held[k] = 1'b1;
                end else if (keys_held[k]) begin
                    which        = 1;
                    keys_held[k] = 1'b0;
                end
                if (which >= 0) begin
                    for (int i = 0; i < KEY_FRAME_LEN[k]; i++) begin
                        beat = '{KEY_FRAMES[k][which][i], i + 1 == KEY_FRAME_LEN[k],
                                 1'b0, 1'b0};
                        burst.push_back(beat);
                    end
                end
            end
        end
        foreach (burst[i]) begin
            beat          = burst[i];
            beat.run_last = (i == burst.size() - 1);
            tx_expected.push_back(beat);
        end
        return burst.size();
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (tx_expected.size() == 0) begin
                    flag_mismatch($sformatf("unexpected tx byte %02h", o_tx_byte));
                end else begin
                    rx_want = tx_expected.pop_front();
                    bytes_checked++;
                    if (o_tx_byte !== rx_want.tx_byte || o_frame_end !== rx_want.frame_end
                        || o_run_last !== rx_want.run_last
                        || o_reboot_pulse !== rx_want.reboot) begin
                        flag_mismatch($sformatf(
                            "byte/end/last/reboot got %02h/%b/%b/%b want %02h/%b/%b/%b",
                            o_tx_byte, o_frame_end, o_run_last, o_reboot_pulse,
                            rx_want.tx_byte, rx_want.frame_end, rx_want.run_last,
                            rx_want.reboot));
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_item(input logic op, input logic [6:0] keys, input logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_key_down <= keys;
        i_rx_byte  <= rx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        last_burst = predict_tx(op, keys, rx);
        items_sent++;
    endtask

    task automatic drain(input int tail);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tx_expected.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic configure(input logic [19:0] tmo, input logic [9:0] scan,
                             input bit spare);
        drain(8);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= kerh_pkg::CFG_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        timeout_reg = tmo;
        i_cfg_idx  <= kerh_pkg::CFG_SCAN;
        i_cfg_data <= {10'($urandom), scan};
        @(posedge i_clk);
        scan_period_reg = scan;
        if (spare) begin
            i_cfg_idx  <= CFG_SPARE_A;
            i_cfg_data <= 20'hFFFFF;
            @(posedge i_clk);
            i_cfg_idx  <= CFG_SPARE_B;
            i_cfg_data <= 20'h00000;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input bit overlong);
        int         sent;
        int         kind;
        int         cpos;
        bit         paused;
        logic [7:0] b;
        sent   = 0;
        paused = 1'b0;
        if (overlong) begin
            // 32 bytes with no close byte, then a clean heartbeat
            send_item(OP_LINK, 7'($urandom), FRAME_OPEN);
            for (int j = 1; j < MAX_FRAME; j++) begin
                b = (j == 2) ? FRAME_OPEN : 8'($urandom);
                if (b == FRAME_CLOSE) b = 8'h5A;
                send_item(OP_LINK, 7'($urandom), b);
            end
            for (int j = 0; j < 5; j++) send_item(OP_LINK, 7'($urandom), HB_BYTES[j]);
        end
        while (sent < n_items) begin
            if (!paused && sent >= n_items / 2) begin
                drain(0);
                paused = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 45) begin
                cur_keys = ($urandom_range(3) == 0) ? 7'($urandom)
                                                    : cur_keys ^ (7'd1 << $urandom_range(6));
                send_item(OP_TICK, cur_keys, 8'($urandom));
                sent++;
            end else if (kind < 70) begin
                cpos = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : -1;
                for (int j = 0; j < 5; j++) begin
                    b = (j == cpos) ? 8'($urandom) : HB_BYTES[j];
                    send_item(OP_LINK, 7'($urandom), b);
                end
                sent += 5;
            end else if (kind < 82) begin
                cpos = $urandom_range(1, 6);
                send_item(OP_LINK, 7'($urandom), FRAME_OPEN);
                for (int j = 0; j < cpos; j++) send_item(OP_LINK, 7'($urandom), 8'($urandom));
                send_item(OP_LINK, 7'($urandom), FRAME_CLOSE);
                sent += cpos + 2;
            end else if (kind < 92) begin
                b = 8'($urandom);
                if (b == FRAME_OPEN) b = 8'h00;
                send_item(OP_LINK, 7'($urandom), b);
                sent++;
            end else begin
                send_item(OP_TICK, 7'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        mismatches     = 0;
        items_sent     = 0;
        bytes_checked  = 0;
        reboots_seen   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_keys       = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        timeout_reg     = 20'd10000;
        scan_period_reg = 10'd100;
        silence_ms      = '0;
        scan_tick       = 10'd1;
        wd_armed        = 1'b0;
        keys_held       = '0;
        in_frame        = 1'b0;
        frame_pos       = '0;
        frame_ok        = 1'b0;

        configure(20'd0, 10'd0, 1'b1);
        foreach (DIRECTED[r]) begin
            send_item(DIRECTED[r].op, DIRECTED[r].keys, DIRECTED[r].rx);
            if (last_burst != DIRECTED[r].n_bytes)
                flag_mismatch($sformatf("directed row %0d: %0d bytes predicted, %0d listed",
                                        r, last_burst, DIRECTED[r].n_bytes));
        end

        configure(20'd3, 10'd1, 1'b0);
        run_phase(15, 1'b1);

        configure(20'hFFFFF, 10'd0, 1'b0);
        send_idle_pct = 76;
        run_phase(20, 1'b0);

        configure(20'd7, 10'd1023, 1'b0);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        run_phase(15, 1'b0);

        // scan period drops below the running scan phase here
        configure(20'd1, 10'd2, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        run_phase(20, 1'b0);

        configure(20'd5, 10'd3, 1'b0);
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        run_phase(15, 1'b0);

        drain(64);
        $display("Sent %0d input transactions over 6 register settings; checked %0d tx bytes,",
                 items_sent, bytes_checked);
        $display("including %0d watchdog reboot frames.", reboots_seen);
        if (mismatches == 0) begin
            $display("** key_event_reporter_with_heartbeat: PASSED **");
        end else begin
            $display("** key_event_reporter_with_heartbeat: FAILED **");
        end
        $finish;
    end

endmodule

[key_event_reporter_with_heartbeat.f]
+incdir+sv
sv/kerh_pkg.sv
sv/kerh_queue.sv
sv/kerh_front.sv
sv/kerh_back.sv
sv/key_event_reporter_with_heartbeat.sv
sv/kerh_checker.sv
verif/key_event_reporter_with_heartbeat_test.sv
